// ===== design/lmse_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lmse_pkg
// Shared types and constants of the line mark-sweep engine.
// ----------------------------------------------------------------------------
package lmse_pkg;

    localparam int LINE_BYTES  = 128;
    localparam int BLOCK_BYTES = 32768;
    localparam int LINES       = 256;

    localparam int SIZE_W      = 16;
    localparam int OFF_W       = 15;
    localparam int NEXT_W      = SIZE_W + 1;
    localparam int LINE_SHIFT  = $clog2(LINE_BYTES);
    localparam int LINE_IDX_W  = $clog2(LINES);
    localparam int LAST_LINE_W = NEXT_W - LINE_SHIFT;
    localparam int WORD_BITS   = 64;
    localparam int MAP_WORDS   = LINES / WORD_BITS;
    localparam int WIDX_W      = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [1:0] MODE_FULL  = 2'd0;
    localparam logic [1:0] MODE_MINOR = 2'd1;
    localparam logic [1:0] MODE_CONC  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SWEEP_MODE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIVE_MARK       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EPOCH_WATERMARK = 2'd2;

    localparam logic [1:0] KIND_VERDICT = 2'd0;
    localparam logic [1:0] KIND_LINE    = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    localparam logic [1:0] ACT_SKIP = 2'd0;
    localparam logic [1:0] ACT_KEEP = 2'd1;
    localparam logic [1:0] ACT_DEAD = 2'd2;

    typedef struct packed {
        logic [SIZE_W-1:0] obj_size;
        logic              obj_mark;
        logic              obj_gen;
        logic [7:0]        obj_survive;
        logic [31:0]       obj_epoch;
    } in_item_t;

    typedef struct packed {
        logic [1:0]           kind;
        logic [OFF_W-1:0]     obj_offset;
        logic [1:0]           action;
        logic                 new_gen;
        logic [7:0]           new_survive;
        logic [OFF_W-1:0]     next_offset;
        logic [WIDX_W-1:0]    line_index;
        logic [WORD_BITS-1:0] line_word;
        logic                 no_lines;
        logic [15:0]          kept_total;
        logic                 last;
    } out_item_t;

    typedef struct packed {
        logic              capture;
        logic              emit_verdict;
        logic              emit_word;
        logic              emit_sum;
        logic [WIDX_W-1:0] word_idx;
    } cmd_t;

    typedef struct packed {
        logic slot_free;
        logic ended;
        logic blk_clear;
    } status_t;

endpackage
`default_nettype wire

// ===== design/lmse_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lmse_if
// Handshake channels of the line mark-sweep engine: header input, result
// output and configuration write.
// ----------------------------------------------------------------------------
interface lmse_in_if;
    logic                valid;
    logic                ready;
    lmse_pkg::in_item_t  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lmse_out_if;
    logic                valid;
    logic                ready;
    lmse_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lmse_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [lmse_pkg::CFG_IDX_W-1:0]    index;
    logic [lmse_pkg::CFG_DATA_W-1:0]   data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== design/lmse_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lmse_ctrl
// Sequencer: takes a header, issues its verdict, then at block end walks
// the line map words and the summary out through the result register.
// ----------------------------------------------------------------------------
module lmse_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire lmse_pkg::status_t sts,
    output lmse_pkg::cmd_t         cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EVAL = 2'd1;
    localparam logic [1:0] ST_MAP  = 2'd2;
    localparam logic [1:0] ST_SUM  = 2'd3;

    logic [1:0]                  state_reg, state_next;
    logic [lmse_pkg::WIDX_W-1:0] widx_reg, widx_next;

    always_comb
    begin
        state_next = state_reg;
        widx_next  = widx_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        cmd.word_idx = widx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit_verdict = 1'b1;
                    widx_next        = '0;
                    state_next       = sts.ended ? ST_MAP : ST_IDLE;
                end
            end
            ST_MAP:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit_word = 1'b1;
                    widx_next     = widx_reg + 1'b1;
                    if (widx_reg == lmse_pkg::WIDX_W'(lmse_pkg::MAP_WORDS - 1))
                        state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit_sum = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            widx_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            widx_reg  <= widx_next;
        end
    end

endmodule
`default_nettype wire

// ===== design/lmse_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lmse_datapath
// Header register, walk cursor, line occupancy map, survivor count,
// configuration registers and the result register.
// ----------------------------------------------------------------------------
module lmse_datapath (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire lmse_pkg::cmd_t                   cmd,
    output lmse_pkg::status_t                     sts,
    input  wire lmse_pkg::in_item_t               in_data,
    input  wire logic                             cfg_we,
    input  wire logic [lmse_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [lmse_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output lmse_pkg::out_item_t                   out_data
);

    localparam int NEXT_W = lmse_pkg::NEXT_W;
    localparam int LINES  = lmse_pkg::LINES;
    localparam logic [LINES-1:0] ALL_ONES = '1;

    lmse_pkg::in_item_t             hdr_reg;
    logic [lmse_pkg::OFF_W-1:0]     cursor_reg, cursor_next;
    logic [LINES-1:0]               map_reg, map_next;
    logic [15:0]                    surv_reg, surv_next;
    logic [1:0]                     mode_reg;
    logic                           live_reg;
    logic [31:0]                    wm_reg;
    lmse_pkg::out_item_t            out_reg, out_next;
    logic                           out_valid_reg, out_valid_next;

    logic                               empty;
    logic                               old_kept;
    logic                               keep;
    logic [lmse_pkg::LINE_IDX_W:0]      line_up;
    logic [NEXT_W-1:0]                  next_off;
    logic                               ended;
    logic [NEXT_W-1:0]                  last_byte;
    logic [lmse_pkg::LAST_LINE_W-1:0]   hi_line;
    logic [lmse_pkg::LINE_IDX_W-1:0]    last_clip;
    logic [lmse_pkg::LINE_IDX_W-1:0]    lo_line;
    logic [LINES-1:0]                   line_mask;
    logic [16:0]                        surv_sum;
    logic [15:0]                        surv_sat;
    logic                               ngen;
    logic [7:0]                         nsurv;

    // Verdict of the held header
    always_comb
    begin
        empty    = (hdr_reg.obj_size == '0);
        old_kept = (mode_reg == lmse_pkg::MODE_MINOR) && hdr_reg.obj_gen;
        keep     = !empty && (old_kept || (hdr_reg.obj_mark == live_reg) ||
                   ((mode_reg == lmse_pkg::MODE_CONC) && (hdr_reg.obj_epoch >= wm_reg)));

        line_up = {1'b0, cursor_reg[lmse_pkg::OFF_W-1:lmse_pkg::LINE_SHIFT]} + 1'b1;
        if (empty)
            next_off = NEXT_W'(line_up) << lmse_pkg::LINE_SHIFT;
        else
            next_off = NEXT_W'(cursor_reg) + NEXT_W'(hdr_reg.obj_size);
        ended = (next_off >= NEXT_W'(lmse_pkg::BLOCK_BYTES));

        // Lines touched, clipped to the end of the map
        lo_line   = cursor_reg[lmse_pkg::OFF_W-1:lmse_pkg::LINE_SHIFT];
        last_byte = NEXT_W'(cursor_reg) + NEXT_W'(hdr_reg.obj_size) - 1'b1;
        hi_line   = last_byte[NEXT_W-1:lmse_pkg::LINE_SHIFT];
        if (hi_line >= lmse_pkg::LAST_LINE_W'(LINES))
            last_clip = lmse_pkg::LINE_IDX_W'(LINES - 1);
        else
            last_clip = hi_line[lmse_pkg::LINE_IDX_W-1:0];
        line_mask = (ALL_ONES << lo_line) &
                    (ALL_ONES >> (lmse_pkg::LINE_IDX_W'(LINES - 1) - last_clip));

        surv_sum = {1'b0, surv_reg} + {1'b0, hdr_reg.obj_size};
        surv_sat = surv_sum[16] ? 16'hFFFF : surv_sum[15:0];

        // Promotion
        ngen  = 1'b0;
        nsurv = '0;
        if (keep)
        begin
            if (hdr_reg.obj_gen || (hdr_reg.obj_survive != '0))
            begin
                ngen  = 1'b1;
                nsurv = hdr_reg.obj_survive;
            end
            else
            begin
                nsurv = 8'd1;
            end
        end
    end

    always_comb
    begin
        cursor_next    = cursor_reg;
        map_next       = map_reg;
        surv_next      = surv_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (cmd.emit_verdict)
        begin
            out_next            = '0;
            out_next.kind       = lmse_pkg::KIND_VERDICT;
            out_next.obj_offset = cursor_reg;
            out_next.action     = empty ? lmse_pkg::ACT_SKIP :
                                  (keep ? lmse_pkg::ACT_KEEP : lmse_pkg::ACT_DEAD);
            out_next.new_gen     = ngen;
            out_next.new_survive = nsurv;
            out_next.next_offset = ended ? '0 : next_off[lmse_pkg::OFF_W-1:0];
            out_next.last        = !ended;
            out_valid_next       = 1'b1;
            cursor_next          = ended ? '0 : next_off[lmse_pkg::OFF_W-1:0];
            if (keep)
            begin
                map_next  = map_reg | line_mask;
                surv_next = surv_sat;
            end
        end
        else if (cmd.emit_word)
        begin
            out_next            = '0;
            out_next.kind       = lmse_pkg::KIND_LINE;
            out_next.line_index = cmd.word_idx;
            out_next.line_word  = map_reg[cmd.word_idx * lmse_pkg::WORD_BITS +:
                                          lmse_pkg::WORD_BITS];
            out_valid_next      = 1'b1;
        end
        else if (cmd.emit_sum)
        begin
            out_next            = '0;
            out_next.kind       = lmse_pkg::KIND_SUMMARY;
            out_next.no_lines   = (map_reg == '0);
            out_next.kept_total = surv_reg;
            out_next.last       = 1'b1;
            out_valid_next      = 1'b1;
            // Clear for the next block
            cursor_next = '0;
            map_next    = '0;
            surv_next   = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            hdr_reg <= in_data;
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg    <= '0;
            map_reg       <= '0;
            surv_reg      <= '0;
            out_valid_reg <= 1'b0;
            mode_reg      <= lmse_pkg::MODE_FULL;
            live_reg      <= 1'b0;
            wm_reg        <= '0;
        end
        else
        begin
            cursor_reg    <= cursor_next;
            map_reg       <= map_next;
            surv_reg      <= surv_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    lmse_pkg::REG_SWEEP_MODE:      mode_reg <= cfg_data[1:0];
                    lmse_pkg::REG_LIVE_MARK:       live_reg <= cfg_data[0];
                    lmse_pkg::REG_EPOCH_WATERMARK: wm_reg   <= cfg_data;
                    default:
                    begin
                        mode_reg <= mode_reg;
                    end
                endcase
            end
        end
    end

    assign sts.slot_free = !out_valid_reg || out_ready;
    assign sts.ended     = ended;
    assign sts.blk_clear = (map_reg == '0) && (surv_reg == '0) && (cursor_reg == '0);
    assign out_valid     = out_valid_reg;
    assign out_data      = out_reg;

endmodule
`default_nettype wire

// ===== design/line_mark_sweep_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// line_mark_sweep_engine
// Line-granular mark-sweep of one heap block, one object header per beat.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one object header per beat, read at the current cursor.
//   out_ch : results. Each header gives one verdict beat; the header that
//            ends the block gives the verdict, four line map words and a
//            summary beat, with last set on the final beat of the header.
//   cfg_ch : register writes (sweep mode, live mark, epoch watermark),
//            always ready; write them only while the engine is idle.
// Timing:
//   A header is captured in ST_IDLE and judged in ST_EVAL, and the next
//   header is not taken until this one is judged; the verdict appears on
//   out_ch the cycle after evaluation. A block end adds 5 more result beats,
//   one per cycle while the receiver keeps up. The single result register
//   sets the pace: while the receiver stalls, the engine holds the result
//   and still takes one more header, which waits until the register frees.
// Reset:
//   Cursor at 0, every line free, survivor count 0, registers at 0, no
//   result pending.
// ----------------------------------------------------------------------------
module line_mark_sweep_engine (
    input  wire logic   clk,
    input  wire logic   rst_n,
    lmse_in_if.sink     in_ch,
    lmse_out_if.source  out_ch,
    lmse_cfg_if.sink    cfg_ch
);

    lmse_pkg::cmd_t    cmd;
    lmse_pkg::status_t sts;

    assign cfg_ch.ready = 1'b1;

    lmse_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lmse_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (in_ch.data),
        .cfg_we    (cfg_ch.valid && cfg_ch.ready),
        .cfg_index (cfg_ch.index),
        .cfg_data  (cfg_ch.data),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_data  (out_ch.data)
    );

    a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.emit_verdict, cmd.emit_word, cmd.emit_sum}))
        else $error("more than one result loaded in a cycle");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_verdict || cmd.emit_word || cmd.emit_sum) |-> sts.slot_free)
        else $error("result loaded over a pending beat");

    a_take_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |-> !(cmd.emit_verdict || cmd.emit_word || cmd.emit_sum))
        else $error("header taken while a result is being loaded");

    a_sum_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_sum |=> sts.blk_clear)
        else $error("block state not cleared after summary");

endmodule
`default_nettype wire
